// File: rtl/core/fsha_pkg.sv
`timescale 1ns / 1ps

package fsha_pkg;

  // mirroring rule selected per transaction
  typedef enum logic {
    OpRead  = 1'b0,
    OpWrite = 1'b1
  } op_e;

  // index limit after reset
  localparam logic [5:0] LimitReset = 6'd63;

  // one input transaction
  typedef struct packed {
    op_e               opcode;
    logic signed [6:0] idx_h;
    logic signed [6:0] idx_k;
    logic signed [6:0] idx_l;
  } in_item_t;

  // one result transaction
  typedef struct packed {
    logic [19:0] word_address;
    logic        mirrored;
    logic        out_of_range;
  } out_item_t;

endpackage

// File: rtl/core/fsha_if.sv
`timescale 1ns / 1ps

// index triple channel
interface fsha_in_if;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic signed [6:0] idx_h;
  logic signed [6:0] idx_k;
  logic signed [6:0] idx_l;

  modport source(output valid, output opcode, output idx_h, output idx_k, output idx_l,
                 input ready);
  modport sink(input valid, input opcode, input idx_h, input idx_k, input idx_l,
               output ready);
endinterface

// address result channel
interface fsha_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] word_address;
  logic        mirrored;
  logic        out_of_range;

  modport source(output valid, output word_address, output mirrored, output out_of_range,
                 input ready);
  modport sink(input valid, input word_address, input mirrored, input out_of_range,
               output ready);
endinterface

// index limit register write channel
interface fsha_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] index_limit;

  modport source(output valid, output index_limit, input ready);
  modport sink(input valid, input index_limit, output ready);
endinterface

// File: rtl/core/friedel_shell_hkl_address.sv
`timescale 1ns / 1ps

// channel   dir  handshake     payload
// in_i      in   valid/ready   opcode, idx_h, idx_k, idx_l
// out_o     out  valid/ready   word_address, mirrored, out_of_range
// cfg_i     in   valid/ready   index_limit
//
// five register stages, one transaction per cycle while the output register is not stalled
// the last stage is the output register; the whole pipe holds while it is stalled
// in_i.ready is high whenever the output register is empty or being taken
// reset clears the stage valid bits and loads index_limit with 63
// cfg_i.ready is always high

module friedel_shell_hkl_address #(
  parameter int MAX_SHELL = 63
) (
  input logic         clk_i,
  input logic         rst_ni,
  fsha_in_if.sink     in_i,
  fsha_out_if.source  out_o,
  fsha_cfg_if.sink    cfg_i
);

  localparam int Stages = 5;

  logic [Stages-1:0]   valid_q;
  logic                advance;
  logic [5:0]          limit_q;
  fsha_pkg::in_item_t  item;
  fsha_pkg::out_item_t res;

  // pipe moves when the output register is free or drained this cycle
  assign advance   = !valid_q[Stages-1] || out_o.ready;
  assign in_i.ready = advance;
  assign cfg_i.ready = 1'b1;

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= {valid_q[Stages-2:0], in_i.valid};
    end
  end

  // index limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= fsha_pkg::LimitReset;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.index_limit;
    end
  end

  // pack input transaction
  always_comb begin
    item.opcode = fsha_pkg::op_e'(in_i.opcode);
    item.idx_h  = in_i.idx_h;
    item.idx_k  = in_i.idx_k;
    item.idx_l  = in_i.idx_l;
  end

  fsha_datapath #(
    .MAX_SHELL(MAX_SHELL)
  ) u_datapath (
    .clk_i  (clk_i),
    .en_i   (advance),
    .item_i (item),
    .limit_i(limit_q),
    .res_o  (res)
  );

  // result channel
  assign out_o.valid        = valid_q[Stages-1];
  assign out_o.word_address = res.word_address;
  assign out_o.mirrored     = res.mirrored;
  assign out_o.out_of_range = res.out_of_range;

endmodule

// File: rtl/core/fsha_datapath.sv
`timescale 1ns / 1ps

module fsha_datapath #(
  parameter int MAX_SHELL = 63
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  fsha_pkg::in_item_t  item_i,
  input  logic [5:0]          limit_i,
  output fsha_pkg::out_item_t res_o
);

  localparam logic [8:0] MaxShellW = 9'(MAX_SHELL);

  // ---------------- stage 1: mirror decision and magnitudes ----------------
  logic              s1_flip;
  logic signed [7:0] s1_hx, s1_kx, s1_lx;
  logic signed [7:0] s1_hc, s1_kc, s1_lc;
  logic        [6:0] s1_ak, s1_al;

  always_comb begin
    s1_hx = {item_i.idx_h[6], item_i.idx_h};
    s1_kx = {item_i.idx_k[6], item_i.idx_k};
    s1_lx = {item_i.idx_l[6], item_i.idx_l};
    if (item_i.opcode == fsha_pkg::OpWrite) begin
      s1_flip = s1_hx < 0;
    end else begin
      s1_flip = (s1_hx < 0) || ((s1_hx == 0) && (s1_kx < 0));
    end
    s1_hc = s1_flip ? -s1_hx : s1_hx;
    s1_kc = s1_flip ? -s1_kx : s1_kx;
    s1_lc = s1_flip ? -s1_lx : s1_lx;
    s1_ak = (s1_kc < 0) ? 7'(-s1_kc) : 7'(s1_kc);
    s1_al = (s1_lc < 0) ? 7'(-s1_lc) : 7'(s1_lc);
  end

  logic              s1_mir_q;
  logic        [6:0] s1_h_q, s1_ak_q, s1_al_q;
  logic signed [7:0] s1_k_q, s1_l_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_mir_q <= s1_flip;
      s1_h_q   <= 7'(s1_hc);  // canonical h is never negative
      s1_k_q   <= s1_kc;
      s1_l_q   <= s1_lc;
      s1_ak_q  <= s1_ak;
      s1_al_q  <= s1_al;
    end
  end

  // ---------------- stage 2: shell, range check, edge terms ----------------
  logic        [6:0]  s2_n, s2_m;
  logic               s2_oor;
  logic signed [8:0]  s2_nn, s2_k, s2_l, s2_a, s2_b, s2_c, s2_d1, s2_d2, s2_t1, s2_t2;
  logic signed [10:0] s2_small;
  logic               s2_corner;

  always_comb begin
    s2_n   = (s1_ak_q > s1_al_q) ? s1_ak_q : s1_al_q;
    s2_m   = (s2_n > s1_h_q) ? s2_n : s1_h_q;
    s2_oor = ({2'd0, s2_m} > {3'd0, limit_i}) || ({2'd0, s2_m} > MaxShellW);
    s2_nn  = {2'b00, s2_n};
    s2_k   = {s1_k_q[7], s1_k_q};
    s2_l   = {s1_l_q[7], s1_l_q};
    s2_a   = s2_nn - 9'sd1 + s2_l;
    s2_b   = s2_k - s2_nn;
    s2_c   = s2_l + s2_nn - 9'sd1;
    s2_d1  = s2_nn - s2_k;
    s2_d2  = s2_nn - s2_l;
    s2_t1  = (s2_a >= 0) ? s2_d1 : -s2_d1;
    // min of -sgn(k-n) and sgn(l+n-1) is +1 only when both are +1
    s2_t2  = ((s2_b < 0) && (s2_c >= 0)) ? s2_d2 : -s2_d2;
    s2_small = {2'b00, s2_nn[6:0], 2'b00} + {{2{s2_t1[8]}}, s2_t1}
             + {{2{s2_t2[8]}}, s2_t2};
    s2_corner = (s1_h_q == s2_m) && ((s1_k_q != 0) || (s1_l_q != 0));
  end

  logic               s2_mir_q, s2_oor_q, s2_corner_q;
  logic        [6:0]  s2_m_q, s2_h_q;
  logic        [7:0]  s2_q_q, s2_r_q;
  logic signed [10:0] s2_small_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_mir_q    <= s1_mir_q;
      s2_oor_q    <= s2_oor;
      s2_corner_q <= s2_corner;
      s2_m_q      <= s2_m;
      s2_h_q      <= s1_h_q;
      s2_q_q      <= {s2_m, 1'b0} - 8'd1;
      s2_r_q      <= {s2_n, 1'b0} - 8'd1;
      s2_small_q  <= s2_small;
    end
  end

  // ---------------- stage 3: squares and h*m ----------------
  logic s3_mir_q, s3_oor_q;
  logic [6:0]         s3_m_q;
  logic [15:0]        s3_q2_q, s3_r2_q;
  logic [16:0]        s3_hm8_q;
  logic signed [10:0] s3_small_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_mir_q   <= s2_mir_q;
      s3_oor_q   <= s2_oor_q;
      s3_m_q     <= s2_m_q;
      s3_q2_q    <= s2_q_q * s2_q_q;
      s3_r2_q    <= s2_corner_q ? 16'(s2_r_q * s2_r_q) : 16'd0;
      s3_hm8_q   <= {14'(s2_h_q * s2_m_q), 3'b000};
      s3_small_q <= s2_small_q;
    end
  end

  // ---------------- stage 4: shell base and partial sum ----------------
  logic        s4_mir_q, s4_oor_q;
  logic [22:0] s4_mq2_q;
  logic [19:0] s4_base_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_mir_q  <= s3_mir_q;
      s4_oor_q  <= s3_oor_q;
      s4_mq2_q  <= s3_m_q * s3_q2_q;
      s4_base_q <= {3'd0, s3_hm8_q} + {4'd0, s3_r2_q} + {{9{s3_small_q[10]}}, s3_small_q};
    end
  end

  // ---------------- stage 5: final address, output register ----------------
  fsha_pkg::out_item_t s5_res_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_res_q.word_address <= s4_oor_q ? 20'd0 : (s4_mq2_q[19:0] + s4_base_q);
      s5_res_q.mirrored     <= s4_mir_q;
      s5_res_q.out_of_range <= s4_oor_q;
    end
  end

  assign res_o = s5_res_q;

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int MaxShell = 63;
  localparam int PipeDepth = 5;
  localparam int CycleLimit = 300000;
  localparam int PhaseCount = 7;

  // expected results and the shell-ordered address predictor
  class address_scoreboard;
    logic [5:0] index_limit;
    fsha_pkg::out_item_t pending_results[$];
    int errors;

    function new();
      index_limit = fsha_pkg::LimitReset;
      errors = 0;
    endfunction

    function int sign_of(int x);
      return (x >= 0) ? 1 : -1;
    endfunction

    function int abs_of(int x);
      return (x < 0) ? -x : x;
    endfunction

    // canonical triple, shell and address of one lookup
    function fsha_pkg::out_item_t predict_address(fsha_pkg::in_item_t it);
      fsha_pkg::out_item_t res;
      int h, k, l, n, m, lim, q, r, addr, s_lo, s_hi;
      bit flip;
      h = int'($signed(it.idx_h));
      k = int'($signed(it.idx_k));
      l = int'($signed(it.idx_l));
      if (it.opcode == fsha_pkg::OpWrite) begin
        flip = (h < 0);
      end else begin
        flip = (h < 0) || (h == 0 && k < 0);
      end
      if (flip) begin
        h = -h;
        k = -k;
        l = -l;
      end
      n = (abs_of(k) > abs_of(l)) ? abs_of(k) : abs_of(l);
      m = (n > abs_of(h)) ? n : abs_of(h);
      lim = (int'(index_limit) < MaxShell) ? int'(index_limit) : MaxShell;
      res.mirrored = flip;
      if (m > lim) begin
        res.word_address = '0;
        res.out_of_range = 1'b1;
        return res;
      end
      q = 2 * m - 1;
      addr = m * q * q + 8 * h * m + 4 * n;
      addr += sign_of(n - 1 + l) * (n - k);
      s_lo = -sign_of(k - n);
      s_hi = sign_of(l + n - 1);
      addr += ((s_lo < s_hi) ? s_lo : s_hi) * (n - l);
      if (h == m && (k != 0 || l != 0)) begin
        r = 2 * n - 1;
        addr += r * r;
      end
      res.word_address = addr[19:0];
      res.out_of_range = 1'b0;
      return res;
    endfunction

    function void note_lookup(fsha_pkg::in_item_t it);
      pending_results = {pending_results, predict_address(it)};
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(fsha_pkg::out_item_t got);
      fsha_pkg::out_item_t exp_res;
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with no lookup pending");
        return;
      end
      exp_res = pending_results.pop_front();
      if (got.word_address !== exp_res.word_address)
        report_mismatch($sformatf("word_address got %0d expected %0d",
                                  got.word_address, exp_res.word_address));
      if (got.mirrored !== exp_res.mirrored)
        report_mismatch($sformatf("mirrored got %b expected %b",
                                  got.mirrored, exp_res.mirrored));
      if (got.out_of_range !== exp_res.out_of_range)
        report_mismatch($sformatf("out_of_range got %b expected %b",
                                  got.out_of_range, exp_res.out_of_range));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int cycle_count = 0;
  int stall_tick = 0;
  logic [12:0] ready_pattern = '1;

  fsha_in_if in_bus();
  fsha_out_if out_bus();
  fsha_cfg_if cfg_bus();

  address_scoreboard sb = new();

  friedel_shell_hkl_address #(
    .MAX_SHELL(MaxShell)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus),
    .cfg_i (cfg_bus)
  );

  // clock
  always #10 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // input transaction monitor
  always @(posedge clk_i) begin : in_monitor
    fsha_pkg::in_item_t seen;
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      seen.opcode = fsha_pkg::op_e'(in_bus.opcode);
      seen.idx_h = in_bus.idx_h;
      seen.idx_k = in_bus.idx_k;
      seen.idx_l = in_bus.idx_l;
      sb.note_lookup(seen);
    end
  end

  // result transaction monitor
  always @(posedge clk_i) begin : out_monitor
    fsha_pkg::out_item_t got;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.word_address = out_bus.word_address;
      got.mirrored = out_bus.mirrored;
      got.out_of_range = out_bus.out_of_range;
      sb.check_result(got);
    end
  end

  // receiver stalls from a rotating pattern, reloaded now and then
  always @(negedge clk_i) begin
    stall_tick++;
    if (stall_tick % 150 == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pattern = '1;
        1: ready_pattern = 13'($urandom) | 13'd1;
        2: ready_pattern = (13'($urandom) & 13'($urandom)) | 13'd1;
        default: ready_pattern = ~(13'($urandom) & 13'($urandom) & 13'($urandom));
      endcase
      if (ready_pattern == '0) ready_pattern = 13'd1;
    end
    out_bus.ready <= ready_pattern[0];
    ready_pattern = {ready_pattern[0], ready_pattern[12:1]};
  end

  function fsha_pkg::in_item_t make_lookup(fsha_pkg::op_e op, int h, int k, int l);
    fsha_pkg::in_item_t it;
    it.opcode = op;
    it.idx_h = 7'(h);
    it.idx_k = 7'(k);
    it.idx_l = 7'(l);
    return it;
  endfunction

  // mostly triples on shells from 0 to one past the limit (at most 63), some raw bit patterns
  function fsha_pkg::in_item_t random_lookup(int lim);
    fsha_pkg::in_item_t it;
    int m, sel, v[3];
    if ($urandom_range(0, 99) < 15) begin
      it.opcode = fsha_pkg::op_e'($urandom_range(0, 1));
      it.idx_h = 7'($urandom);
      it.idx_k = 7'($urandom);
      it.idx_l = 7'($urandom);
      return it;
    end
    m = $urandom_range(0, (lim < MaxShell) ? lim + 1 : MaxShell);
    for (int i = 0; i < 3; i++) v[i] = int'($urandom_range(0, 2 * m)) - m;
    sel = $urandom_range(0, 2);
    v[sel] = $urandom_range(0, 1) ? m : -m;
    if ($urandom_range(0, 7) == 0) v[0] = 0;
    return make_lookup(fsha_pkg::op_e'($urandom_range(0, 1)), v[0], v[1], v[2]);
  endfunction

  // one lookup transaction; valid stays high for back-to-back items
  task push_lookup(fsha_pkg::in_item_t it);
    @(negedge clk_i);
    in_bus.valid <= 1'b1;
    in_bus.opcode <= it.opcode;
    in_bus.idx_h <= it.idx_h;
    in_bus.idx_k <= it.idx_k;
    in_bus.idx_l <= it.idx_l;
    do @(posedge clk_i); while (!in_bus.ready);
  endtask

  task idle_input(int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
    end
  endtask

  // bursts of random lookups with random gaps
  task run_lookups(int count, int lim);
    int left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && left > 0; i++) begin
        push_lookup(random_lookup(lim));
        left--;
      end
      if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 6));
    end
  endtask

  // stop sending and wait for every pending result
  task drain_results();
    idle_input(1);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 3) @(posedge clk_i);
  endtask

  task write_limit(logic [5:0] value);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index_limit <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    sb.index_limit = value;
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // stimulus
  initial begin : stimulus
    fsha_pkg::in_item_t directed[$];
    int lim;
    rst_ni = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.opcode = fsha_pkg::OpRead;
    in_bus.idx_h = '0;
    in_bus.idx_k = '0;
    in_bus.idx_l = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index_limit = fsha_pkg::LimitReset;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // origin, extremes, mirroring rules, index -64, top face of the shell
    directed = {directed, make_lookup(fsha_pkg::OpRead, 0, 0, 0)};
    directed = {directed, make_lookup(fsha_pkg::OpWrite, 0, 0, 0)};
    directed = {directed, make_lookup(fsha_pkg::OpRead, 63, 63, 63)};
    directed = {directed, make_lookup(fsha_pkg::OpWrite, -63, -63, -63)};
    directed = {directed, make_lookup(fsha_pkg::OpRead, -63, 63, -63)};
    directed = {directed, make_lookup(fsha_pkg::OpRead, 0, -5, 3)};
    directed = {directed, make_lookup(fsha_pkg::OpWrite, 0, -5, 3)};
    directed = {directed, make_lookup(fsha_pkg::OpRead, 0, 0, -7)};
    directed = {directed, make_lookup(fsha_pkg::OpRead, -64, 0, 0)};
    directed = {directed, make_lookup(fsha_pkg::OpWrite, 0, -64, 5)};
    directed = {directed, make_lookup(fsha_pkg::OpRead, 3, 2, -64)};
    directed = {directed, make_lookup(fsha_pkg::OpRead, 5, 2, -3)};
    directed = {directed, make_lookup(fsha_pkg::OpWrite, 5, 0, 0)};
    directed = {directed, make_lookup(fsha_pkg::OpRead, 1, 0, 0)};
    directed = {directed, make_lookup(fsha_pkg::OpRead, 0, 1, 0)};
    directed = {directed, make_lookup(fsha_pkg::OpRead, 0, 0, 1)};
    directed = {directed, make_lookup(fsha_pkg::OpRead, 0, 0, -1)};
    directed = {directed, make_lookup(fsha_pkg::OpRead, 0, -1, 0)};
    directed = {directed, make_lookup(fsha_pkg::OpWrite, -1, 0, 0)};
    directed = {directed, make_lookup(fsha_pkg::OpRead, 63, -63, 0)};
    directed = {directed, make_lookup(fsha_pkg::OpWrite, 62, -1, 62)};
    directed = {directed, make_lookup(fsha_pkg::OpRead, -3, 4, -4)};
    directed = {directed, make_lookup(fsha_pkg::OpWrite, 0, -63, -63)};
    foreach (directed[i]) push_lookup(directed[i]);
    drain_results();

    // random phases over several index limits, extremes included
    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: lim = 0;
        1: lim = 1;
        2: lim = 63;
        3: lim = 10;
        5: lim = 62;
        default: lim = $urandom_range(0, 63);
      endcase
      write_limit(6'(lim));
      run_lookups(100, lim);
      drain_results();
    end

    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
